// ===== sv/pf_pkg.sv =====
// Shared types, constants and letter/cell helper functions for the Playfair cipher block.
// Used by pf_ctrl, pf_dp and playfair_digraph_cipher_top; depends on nothing else.
package pf_pkg;

   typedef logic [4:0] letter_type;
   typedef logic [4:0] cell_type;
   typedef logic [2:0] pos_type;
   typedef logic [1:0] mode_type;

   localparam mode_type MODE_CLEAR  = 2'd0;
   localparam mode_type MODE_KEY    = 2'd1;
   localparam mode_type MODE_FINISH = 2'd2;
   localparam mode_type MODE_PAIR   = 2'd3;

   localparam int SIDE    = 5;
   localparam int CELLS   = 25;
   localparam int LETTERS = 26;

   localparam letter_type LETTER_I = 5'd8;
   localparam letter_type LETTER_J = 5'd9;
   localparam letter_type LETTER_Z = 5'd25;
   localparam cell_type   CELL_FULL = 5'(CELLS);
   localparam pos_type    POS_LAST  = 3'(SIDE - 1);

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear;
      logic add_key;
      logic start_fill;
      logic fill_step;
      logic pair_lookup;
      logic pair_read;
      logic out_load;
   } pf_cmd_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic fill_last;
      logic out_busy;
   } pf_status_type;

   function automatic letter_type fold_j(letter_type l);
      return (l == LETTER_J) ? LETTER_I : l;
   endfunction

   // Plaintext letters above z count as z, and j counts as i.
   function automatic letter_type plain_letter(letter_type l);
      letter_type c;
      c = (l > LETTER_Z) ? LETTER_Z : l;
      return fold_j(c);
   endfunction

   function automatic pos_type cell_row(cell_type c);
      pos_type r;
      if (c >= 5'd20)      r = 3'd4;
      else if (c >= 5'd15) r = 3'd3;
      else if (c >= 5'd10) r = 3'd2;
      else if (c >= 5'd5)  r = 3'd1;
      else                 r = 3'd0;
      return r;
   endfunction

   function automatic cell_type cell_index(pos_type r, pos_type k);
      return 5'({r, 2'b00}) + 5'(r) + 5'(k);
   endfunction

   function automatic pos_type cell_col(cell_type c);
      cell_type d;
      d = c - cell_index(cell_row(c), 3'd0);
      return d[2:0];
   endfunction

   function automatic pos_type next_pos(pos_type p);
      return (p == POS_LAST) ? 3'd0 : p + 3'd1;
   endfunction

endpackage

// ===== sv/playfair_digraph_cipher_top.sv =====
// Top level of the Playfair digraph cipher block: stream ports, controller and datapath.
// Depends on pf_pkg, pf_ctrl and pf_dp.
//
// Usage. Words enter on the req_ channel; req_tuser carries the mode and req_tdata the
// letters (indices 0 to 25, a is 0). A clear word empties the square, a key word places
// one key letter (j folds into i), a finish word fills the remaining letters in order,
// and a pair word encrypts two plaintext letters. Only pair words produce a result word
// on the rsp_ channel, carrying the two cipher letters.
// Timing. Clear and key words are applied while the controller stays idle. A finish word walks
// the alphabet one letter per cycle, and no further word is accepted until the walk ends. A
// pair word runs a position lookup in the letter store, a read of the key square, then the
// load of the output register; no further word is accepted until that load is done, so one
// pair is finished before the next word is taken.
// Reset clears the used-letter flags, the fill count, the alphabet counter, the controller and
// the output valid; the square contents are left as they are and are meaningful only once written.
// Stalls. The output register holds a result until rsp_tready takes it. Meanwhile clear,
// key and finish words are still accepted; a further pair word runs its lookup and square
// read and then waits, with req_tready low, until the register is free for its final load.
module playfair_digraph_cipher_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [4:0] first_letter, [9:5] second_letter, rest zero
   input  logic [1:0]  req_tuser,   // [1:0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [4:0] cipher_first, [9:5] cipher_second, rest zero
);
   import pf_pkg::*;

   pf_cmd_type    cmd;
   pf_status_type status;
   letter_type    cipher_first, cipher_second;

   pf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_mode   (req_tuser),
      .status     (status),
      .cmd        (cmd)
   );

   pf_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .first_letter  (req_tdata[4:0]),
      .second_letter (req_tdata[9:5]),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .cipher_first  (cipher_first),
      .cipher_second (cipher_second)
   );

   // The unused upper bits of the result word are tied to zero.
   assign rsp_tdata = {6'b000000, cipher_second, cipher_first};

endmodule

// ===== sv/pf_ctrl.sv =====
// Sequencer for the Playfair cipher block: decodes each accepted word and steps
// the datapath through square filling and pair encryption. Depends on pf_pkg.
module pf_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  pf_pkg::mode_type      req_mode,
   input  pf_pkg::pf_status_type status,
   output pf_pkg::pf_cmd_type    cmd
);
   import pf_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_FILL = 2'd1;
   localparam logic [1:0] ST_CELL = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_mode)
                  MODE_CLEAR: cmd.clear = 1'b1;
                  MODE_KEY:   cmd.add_key = 1'b1;
                  MODE_FINISH: begin
                     cmd.start_fill = 1'b1;
                     state_in       = ST_FILL;
                  end
                  MODE_PAIR: begin
                     cmd.pair_lookup = 1'b1;
                     state_in        = ST_CELL;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (status.fill_last) state_in = ST_IDLE;
         end
         ST_CELL: begin
            cmd.pair_read = 1'b1;
            state_in      = ST_OUT;
         end
         ST_OUT: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_fill_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL && status.fill_last) |=> state_ff == ST_IDLE)
      else $error("fill walk did not return to idle");

   a_pair_seq: assert property (@(posedge clock) disable iff (reset)
      cmd.pair_lookup |=> cmd.pair_read)
      else $error("pair lookup not followed by square read");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !status.out_busy)
      else $error("result loaded into a busy output register");

endmodule

// ===== sv/pf_dp.sv =====
// Datapath of the Playfair cipher block: key square and letter position stores,
// used-letter flags, fill counter, pair lookup and the output register. Depends on pf_pkg.
module pf_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  pf_pkg::pf_cmd_type    cmd,
   output pf_pkg::pf_status_type status,
   input  pf_pkg::letter_type    first_letter,
   input  pf_pkg::letter_type    second_letter,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output pf_pkg::letter_type    cipher_first,
   output pf_pkg::letter_type    cipher_second
);
   import pf_pkg::*;

   logic [LETTERS-1:0] letter_used_ff, letter_used_in;
   cell_type           fill_count_ff;
   letter_type         letter_ctr_ff;
   logic               rsp_valid_ff;

   letter_type key_square_ff  [CELLS];
   cell_type   letter_cell_ff [LETTERS];

   logic       hit_a_ff, hit_b_ff;
   cell_type   cell_a_ff, cell_b_ff;
   letter_type sq_a_ff, sq_b_ff;
   letter_type cipher_first_ff, cipher_second_ff;

   letter_type place_letter, look_a, look_b;
   logic       place_req, do_place;
   cell_type   c1, c2, o1, o2;
   pos_type    r1, r2, k1, k2;

   // Letter placement: one key letter, or one step of the alphabet walk.
   always_comb begin
      place_letter = '0;
      place_req    = 1'b0;
      priority if (cmd.add_key) begin
         place_letter = fold_j(first_letter);
         place_req    = (first_letter <= LETTER_Z);
      end else if (cmd.fill_step) begin
         place_letter = letter_ctr_ff;
         place_req    = (letter_ctr_ff != LETTER_J);
      end else begin
         place_req    = 1'b0;
      end
      do_place       = place_req && !letter_used_ff[place_letter]
                       && (fill_count_ff < CELL_FULL);
      letter_used_in = letter_used_ff | (LETTERS'(1) << place_letter);
   end

   assign look_a = plain_letter(first_letter);
   assign look_b = plain_letter(second_letter);

   // Playfair rules on the located cells.
   always_comb begin
      c1 = hit_a_ff ? cell_a_ff : '0;
      c2 = hit_b_ff ? cell_b_ff : '0;
      r1 = cell_row(c1);
      k1 = cell_col(c1);
      r2 = cell_row(c2);
      k2 = cell_col(c2);
      if (r1 == r2) begin
         o1 = cell_index(r1, next_pos(k1));
         o2 = cell_index(r2, next_pos(k2));
      end else if (k1 == k2) begin
         o1 = cell_index(next_pos(r1), k1);
         o2 = cell_index(next_pos(r2), k2);
      end else begin
         o1 = cell_index(r1, k2);
         o2 = cell_index(r2, k1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         letter_used_ff <= '0;
         fill_count_ff  <= '0;
         letter_ctr_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (cmd.clear) begin
            letter_used_ff <= '0;
            fill_count_ff  <= '0;
         end else if (do_place) begin
            letter_used_ff <= letter_used_in;
            fill_count_ff  <= fill_count_ff + 5'd1;
         end
         if (cmd.start_fill) begin
            letter_ctr_ff <= '0;
         end else if (cmd.fill_step) begin
            letter_ctr_ff <= letter_ctr_ff + 5'd1;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_place) begin
         key_square_ff[fill_count_ff] <= place_letter;
         letter_cell_ff[place_letter] <= fill_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pair_lookup) begin
         cell_a_ff <= letter_cell_ff[look_a];
         cell_b_ff <= letter_cell_ff[look_b];
         hit_a_ff  <= letter_used_ff[look_a];
         hit_b_ff  <= letter_used_ff[look_b];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pair_read) begin
         sq_a_ff <= key_square_ff[o1];
         sq_b_ff <= key_square_ff[o2];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         cipher_first_ff  <= sq_a_ff;
         cipher_second_ff <= sq_b_ff;
      end
   end

   assign status.fill_last = (letter_ctr_ff == LETTER_Z);
   assign status.out_busy  = rsp_valid_ff && !rsp_tready;
   assign rsp_tvalid       = rsp_valid_ff;
   assign cipher_first     = cipher_first_ff;
   assign cipher_second    = cipher_second_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= CELL_FULL)
      else $error("fill count beyond square size");

   a_used_count: assert property (@(posedge clock) disable iff (reset)
      $countones(letter_used_ff) == 32'(fill_count_ff))
      else $error("used letters and fill count disagree");

   a_place_step: assert property (@(posedge clock) disable iff (reset)
      do_place |=> fill_count_ff == $past(fill_count_ff) + 5'd1)
      else $error("placement did not advance the fill count");

endmodule
